// ----- src/lcmc_pkg.sv -----
// shared types and constants for the lru cache miss classifier
// no dependencies
package lcmc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int ADDR_BITS_DEF   = 20;

    localparam int SHIFT_W   = 4;
    localparam int CAP_W     = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 32;
    localparam int CLS_W     = 3;
    localparam int OUT_W     = 72;
    localparam int ROW_W     = 64;
    localparam int BIT_W     = 6;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd2;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd8;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 7'd64;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_SHIFT = 1'b0,
        CFG_CAPACITY   = 1'b1
    } t_cfg_idx;

    typedef enum logic [CLS_W-1:0] {
        CLS_RD_HIT      = 3'd0,
        CLS_RD_CAPACITY = 3'd1,
        CLS_RD_FIRST    = 3'd2,
        CLS_WR_HIT      = 3'd3,
        CLS_WR_CAPACITY = 3'd4,
        CLS_WR_FIRST    = 3'd5
    } t_cls;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD
    } t_state;

    typedef struct packed {
        logic flush;
        logic hit;
        logic miss;
    } t_cell_ctl;

endpackage

// ----- src/lru_cache_miss_classifier_unit.sv -----
// top level of the lru cache miss classifier: control, counters, seen-line memory
// depends on lcmc_pkg, lcmc_ram and lcmc_cell
//
// Each access first reads the seen-line memory row of the line, then compares the line
// against every stack cell at once, classes it, writes the row back and shifts the cell
// chain. A new access is taken while a result waits in the output register; the update
// cycle stalls only while that register is still full.
// After reset and after every flush the seen-line memory is swept, one 64-bit row a
// cycle, through all 2^(ADDR_BITS-8) rows (4096 at the default width) with the input held off.
module lru_cache_miss_classifier_unit
    import lcmc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    localparam int IN_W = ((ADDR_BITS + 1 + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // address, is_read
    input  logic                 s_axis_tuser,   // opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // access_class, hit_count, miss_count
);

    localparam int TAG_W     = ADDR_BITS - 2;
    localparam int SEEN_ROWS = 1 << (ADDR_BITS - 8);
    localparam int ROW_AW    = (SEEN_ROWS > 1) ? $clog2(SEEN_ROWS) : 1;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(SEEN_ROWS - 1);

    t_state              r_state, n_state;
    logic [SHIFT_W-1:0]  r_line_shift;
    logic [CAP_W-1:0]    r_capacity;
    logic [ROW_AW-1:0]   r_clr_addr;
    logic [TAG_W-1:0]    r_line;
    logic                r_rd;
    logic [CNT_W-1:0]    r_hits, r_misses;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic [SHIFT_W-1:0]  w_shift;
    logic [ADDR_BITS-1:0] w_addr;
    logic [TAG_W-1:0]    w_in_line;
    logic                w_accept;
    logic                w_flush;
    logic                w_commit;
    logic                w_slot_free;
    logic                w_seen;
    logic                w_is_hit;
    t_cls                w_cls;
    logic [CNT_W-1:0]    n_hits, n_misses;
    t_cell_ctl           w_ctl;

    logic                w_ram_we;
    logic [ROW_AW-1:0]   w_ram_waddr;
    logic [ROW_W-1:0]    w_ram_wdata;
    logic [ROW_W-1:0]    w_ram_rdata;

    logic [TAG_W-1:0]       w_tag   [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] w_valid;
    logic [STACK_DEPTH-1:0] w_match;
    logic [STACK_DEPTH:0]   w_found;
    logic                   w_any;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_shift <= SHIFT_RESET;
            r_capacity   <= CAP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LINE_SHIFT: r_line_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_CAPACITY:   r_capacity   <= i_cfg_data[CAP_W-1:0];
                default:        ;
            endcase
        end
    end

    // line address of the incoming transfer
    always_comb begin
        w_shift = r_line_shift;
        if (r_line_shift < SHIFT_MIN) begin
            w_shift = SHIFT_MIN;
        end else if (r_line_shift > SHIFT_MAX) begin
            w_shift = SHIFT_MAX;
        end
    end

    assign w_addr    = s_axis_tdata[ADDR_BITS-1:0];
    assign w_in_line = TAG_W'(w_addr >> w_shift);

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_flush     = w_accept && s_axis_tuser;
    assign w_slot_free = !r_out_valid || m_axis_tready;

    // next state and handshake
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_commit      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = s_axis_tuser ? S_CLEAR : S_UPD;
                end
            end
            S_UPD: begin
                if (w_slot_free) begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_flush) begin
                r_clr_addr <= '0;
            end else if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_line <= w_in_line;
            r_rd   <= s_axis_tdata[ADDR_BITS];
        end
    end

    // seen-line memory, one bit per line in 64-bit rows
    assign w_ram_we    = (r_state == S_CLEAR) || w_commit;
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : ROW_AW'(r_line >> BIT_W);
    assign w_ram_wdata = (r_state == S_CLEAR) ? '0
                       : (w_ram_rdata | (ROW_W'(1) << r_line[BIT_W-1:0]));

    lcmc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SEEN_ROWS)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (ROW_AW'(w_in_line >> BIT_W)),
        .o_rdata (w_ram_rdata)
    );

    assign w_seen = w_ram_rdata[r_line[BIT_W-1:0]];

    // lru stack as a chain of cells
    assign w_found[0] = 1'b0;
    assign w_any      = w_found[STACK_DEPTH];
    assign w_is_hit   = w_seen && w_any;

    assign w_ctl.flush = w_flush;
    assign w_ctl.hit   = w_commit && w_is_hit;
    assign w_ctl.miss  = w_commit && !w_is_hit;

    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        logic [TAG_W-1:0] w_prev_tag;
        logic             w_prev_valid;
        if (gi == 0) begin : g_head
            assign w_prev_tag   = r_line;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_tag   = w_tag[gi-1];
            assign w_prev_valid = w_valid[gi-1];
        end
        lcmc_cell #(
            .TAG_W (TAG_W),
            .INDEX (gi)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cap        (r_capacity),
            .i_line       (r_line),
            .i_prev_tag   (w_prev_tag),
            .i_prev_valid (w_prev_valid),
            .i_found      (w_found[gi]),
            .o_tag        (w_tag[gi]),
            .o_valid      (w_valid[gi]),
            .o_match      (w_match[gi]),
            .o_found      (w_found[gi+1])
        );
    end

    // classification and counters
    always_comb begin
        if (!w_seen) begin
            w_cls = r_rd ? CLS_RD_FIRST : CLS_WR_FIRST;
        end else if (!w_any) begin
            w_cls = r_rd ? CLS_RD_CAPACITY : CLS_WR_CAPACITY;
        end else begin
            w_cls = r_rd ? CLS_RD_HIT : CLS_WR_HIT;
        end
    end

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (w_is_hit) begin
            if (r_hits != CNT_MAX) begin
                n_hits = r_hits + 1'b1;
            end
        end else if (r_misses != CNT_MAX) begin
            n_misses = r_misses + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_flush) begin
            r_hits   <= '0;
            r_misses <= '0;
        end else if (w_commit) begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= OUT_W'({n_misses, n_hits, w_cls});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("stack valid bits are not a prefix");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("line resident in more than one cell");

    a_first_not_resident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) && !w_seen |-> !w_any)
        else $error("unseen line found in the stack");

    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> m_axis_tvalid && (r_state == S_IDLE))
        else $error("committed access gave no result");

endmodule

// ----- src/lcmc_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module lcmc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/lcmc_cell.sv -----
// one entry of the lru stack: tag, valid bit and match logic
// depends on lcmc_pkg
module lcmc_cell
    import lcmc_pkg::*;
#(
    parameter int TAG_W = 18,
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [CAP_W-1:0]  i_cap,
    input  logic [TAG_W-1:0]  i_line,
    input  logic [TAG_W-1:0]  i_prev_tag,
    input  logic              i_prev_valid,
    input  logic              i_found,
    output logic [TAG_W-1:0]  o_tag,
    output logic              o_valid,
    output logic              o_match,
    output logic              o_found
);

    logic [TAG_W-1:0] r_tag;
    logic             r_valid;
    logic             w_cap_ok;

    assign w_cap_ok = 32'(i_cap) > 32'(INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.flush) begin
            r_valid <= 1'b0;
        end else if (i_ctl.miss) begin
            r_valid <= i_prev_valid && w_cap_ok;
        end
    end

    // on a hit only the cells up to the matching one move down
    always_ff @(posedge i_clk) begin
        if (i_ctl.miss || (i_ctl.hit && !i_found)) begin
            r_tag <= i_prev_tag;
        end
    end

    assign o_tag   = r_tag;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_tag == i_line);
    assign o_found = i_found || o_match;

endmodule
